[rtl/wdr_pkg.sv]
// Shared types, widths and codes for the Weyl dominant reflector.
`timescale 1ns / 1ps
package wdr_pkg;

    localparam int RANK       = 8;
    localparam int MAX_STEPS  = 128;

    localparam int NUM_COORDS = 8;
    localparam int NUM_ROWS   = 8;
    localparam int IN_W       = 11;
    localparam int COORD_W    = 16;
    localparam int DOM_W      = 15;
    localparam int ENTRY_W    = 3;
    localparam int ROW_W      = NUM_COORDS * ENTRY_W;
    localparam int PROD_W     = COORD_W + ENTRY_W;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int RANK_IDX_W = (RANK > 1) ? $clog2(RANK) : 1;

    typedef enum logic [1:0] {
        STATUS_WALL  = 2'd0,
        STATUS_PLUS  = 2'd1,
        STATUS_MINUS = 2'd2,
        STATUS_OVER  = 2'd3
    } status_t;

    // Result of the merge stage over all lane sign flags.
    typedef struct packed {
        logic                  found;
        logic                  wall;
        logic [RANK_IDX_W-1:0] idx;
    } scan_t;

endpackage

[rtl/weyl_dominant_reflector_unit.sv]
// Top level of the Weyl dominant reflector: control, lanes, merge and result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready, coord_0..coord_7): one request carries a
//   rho-shifted weight in fundamental-weight coordinates, 11-bit signed.
//   Output channel (out_valid/out_ready, dom_0..dom_7, status): one result per
//   request, the dominant vector and its status (wall, plus, minus, overflow).
//   Configuration: cfg_we/cfg_index/cfg_data write Cartan rows 0..7; indexes
//   of 8 and above are ignored. Write only while the block is idle.
// Sequencing:
//   A request runs from acceptance to a loaded result register as one
//   scan-and-reflect step per simple reflection, across all eight lanes at
//   once, then a final scan (skipped when a reflection overflows) and the
//   load of the output register. Reflections are capped at MAX_STEPS; the
//   longest E8 Weyl element has 120 reflections. One request is worked on
//   at a time; in_ready is high while the sequencer is idle, even when a
//   result still sits unread in the output register. The next request can
//   be taken in the cycle after the result loads.
// Reset: clears the sequencer and output valid, and loads the diagonal
//   Cartan rows (entry i of row i is 2).
// Stall: a result waits in the finish state until the output register frees.
module weyl_dominant_reflector_unit
    import wdr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_W-1:0]      coord_0,
    input  logic [IN_W-1:0]      coord_1,
    input  logic [IN_W-1:0]      coord_2,
    input  logic [IN_W-1:0]      coord_3,
    input  logic [IN_W-1:0]      coord_4,
    input  logic [IN_W-1:0]      coord_5,
    input  logic [IN_W-1:0]      coord_6,
    input  logic [IN_W-1:0]      coord_7,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DOM_W-1:0]     dom_0,
    output logic [DOM_W-1:0]     dom_1,
    output logic [DOM_W-1:0]     dom_2,
    output logic [DOM_W-1:0]     dom_3,
    output logic [DOM_W-1:0]     dom_4,
    output logic [DOM_W-1:0]     dom_5,
    output logic [DOM_W-1:0]     dom_6,
    output logic [DOM_W-1:0]     dom_7,
    output logic [1:0]           status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    state_t                    state_reg, state_next;
    logic [ROW_W-1:0]          cartan_reg [NUM_ROWS];
    logic signed [COORD_W-1:0] n_reg      [RANK];
    logic signed [COORD_W-1:0] n_next     [RANK];
    logic [STEP_W-1:0]         steps_reg, steps_next;
    logic                      minus_reg, minus_next;
    status_t                   fin_reg, fin_next;
    logic [DOM_W-1:0]          dom_reg    [NUM_COORDS];
    logic [DOM_W-1:0]          dom_next   [NUM_COORDS];
    status_t                   status_reg, status_next;
    logic                      out_valid_reg, out_valid_next;

    logic [IN_W-1:0]           coord_in   [NUM_COORDS];
    logic signed [COORD_W-1:0] n_refl     [RANK];
    logic [RANK-1:0]           lane_over;
    logic [RANK-1:0]           lane_neg;
    logic [RANK-1:0]           lane_zero;
    logic signed [COORD_W-1:0] v_sel;
    logic [ROW_W-1:0]          row_sel;
    scan_t                     scan;
    logic                      out_free;

    assign coord_in[0] = coord_0;
    assign coord_in[1] = coord_1;
    assign coord_in[2] = coord_2;
    assign coord_in[3] = coord_3;
    assign coord_in[4] = coord_4;
    assign coord_in[5] = coord_5;
    assign coord_in[6] = coord_6;
    assign coord_in[7] = coord_7;

    // Pivot value and Cartan row chosen by the merge stage.
    assign v_sel   = n_reg[scan.idx];
    assign row_sel = cartan_reg[scan.idx];

    for (genvar k = 0; k < RANK; k++)
    begin : g_lane
        wdr_lane u_lane (
            .n      (n_reg[k]),
            .v      (v_sel),
            .c      (row_sel[ENTRY_W*k +: ENTRY_W]),
            .n_refl (n_refl[k]),
            .over   (lane_over[k]),
            .neg    (lane_neg[k]),
            .zero   (lane_zero[k])
        );
    end

    wdr_scan u_scan (
        .neg  (lane_neg),
        .zero (lane_zero),
        .scan (scan)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        steps_next     = steps_reg;
        minus_next     = minus_reg;
        fin_next       = fin_reg;
        dom_next       = dom_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // sign-extend the request into the working vector
                    for (int i = 0; i < RANK; i++)
                    begin
                        n_next[i] = COORD_W'($signed(coord_in[i]));
                    end
                    steps_next = '0;
                    minus_next = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (scan.wall)
                begin
                    fin_next   = STATUS_WALL;
                    state_next = ST_FIN;
                end
                else if (!scan.found)
                begin
                    fin_next   = minus_reg ? STATUS_MINUS : STATUS_PLUS;
                    state_next = ST_FIN;
                end
                else if (steps_reg == STEP_W'(MAX_STEPS))
                begin
                    fin_next   = STATUS_OVER;
                    state_next = ST_FIN;
                end
                else
                begin
                    // apply the simple reflection on every lane at once
                    n_next     = n_refl;
                    steps_next = STEP_W'(steps_reg + 1'b1);
                    minus_next = !minus_reg;
                    if (|lane_over)
                    begin
                        fin_next   = STATUS_OVER;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                // hold the result until the output register frees
                if (out_free)
                begin
                    for (int i = 0; i < NUM_COORDS; i++)
                    begin
                        dom_next[i] = '0;
                    end
                    if (fin_reg == STATUS_PLUS || fin_reg == STATUS_MINUS)
                    begin
                        for (int i = 0; i < RANK; i++)
                        begin
                            dom_next[i] = n_reg[i][DOM_W-1:0];
                        end
                    end
                    status_next    = fin_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            minus_reg     <= 1'b0;
            fin_reg       <= STATUS_WALL;
            status_reg    <= STATUS_WALL;
            for (int i = 0; i < NUM_ROWS; i++)
            begin
                cartan_reg[i] <= ROW_W'(2) << (ENTRY_W * i);
            end
            for (int i = 0; i < RANK; i++)
            begin
                n_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                dom_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            minus_reg     <= minus_next;
            fin_reg       <= fin_next;
            status_reg    <= status_next;
            n_reg         <= n_next;
            dom_reg       <= dom_next;
            // drop writes beyond the last row
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_ROWS)))
            begin
                cartan_reg[cfg_index[$clog2(NUM_ROWS)-1:0]] <= cfg_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign dom_0     = dom_reg[0];
    assign dom_1     = dom_reg[1];
    assign dom_2     = dom_reg[2];
    assign dom_3     = dom_reg[3];
    assign dom_4     = dom_reg[4];
    assign dom_5     = dom_reg[5];
    assign dom_6     = dom_reg[6];
    assign dom_7     = dom_reg[7];

endmodule

[rtl/wdr_lane.sv]
// One coordinate lane: sign flags and the reflected value with overflow check.
`timescale 1ns / 1ps
module wdr_lane
    import wdr_pkg::*;
(
    input  logic signed [COORD_W-1:0] n,
    input  logic signed [COORD_W-1:0] v,
    input  logic signed [ENTRY_W-1:0] c,
    output logic signed [COORD_W-1:0] n_refl,
    output logic                      over,
    output logic                      neg,
    output logic                      zero
);

    logic signed [PROD_W-1:0] prod;
    logic signed [DIFF_W-1:0] diff;

    assign neg  = n[COORD_W-1];
    assign zero = (n == '0);

    assign prod = $signed({{ENTRY_W{v[COORD_W-1]}}, v})
                * $signed({{COORD_W{c[ENTRY_W-1]}}, c});
    assign diff = $signed({{(DIFF_W-COORD_W){n[COORD_W-1]}}, n})
                - $signed({prod[PROD_W-1], prod});

    assign n_refl = diff[COORD_W-1:0];
    // out of 16-bit signed range when the upper bits are not a sign extension
    assign over   = (diff[DIFF_W-1:COORD_W-1] != '0) && (diff[DIFF_W-1:COORD_W-1] != '1);

endmodule

[rtl/wdr_scan.sv]
// Merge stage: find the first non-positive coordinate across the lanes.
`timescale 1ns / 1ps
module wdr_scan
    import wdr_pkg::*;
(
    input  logic [RANK-1:0] neg,
    input  logic [RANK-1:0] zero,
    output scan_t           scan
);

    logic [RANK-1:0]       hit;
    logic [RANK_IDX_W-1:0] first;

    assign hit = neg | zero;

    // lowest index wins
    always_comb
    begin
        first = '0;
        for (int i = RANK - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first = RANK_IDX_W'(i);
            end
        end
    end

    assign scan.found = |hit;
    assign scan.wall  = (|hit) && zero[first];
    assign scan.idx   = first;

endmodule

[dv/wdr_tb_pkg.sv]
// Scoreboard class for the Weyl dominant reflector: chamber-folding prediction and checks.
`timescale 1ns / 1ps
package wdr_tb_pkg;
    import wdr_pkg::*;

    typedef logic [NUM_COORDS-1:0][IN_W-1:0]  weight_t;
    typedef logic [NUM_COORDS-1:0][DOM_W-1:0] dom_vec_t;
    typedef logic [ROW_W-1:0]                 cartan_row_t;

    typedef struct packed {
        dom_vec_t dom;
        status_t  status;
    } dominant_t;

    class dominant_result_book;
        cartan_row_t cartan[NUM_ROWS];
        dominant_t   pending_dominants[$];
        int          mismatch_count;

        function new();
            for (int i = 0; i < NUM_ROWS; i++)
                cartan[i] = cartan_row_t'(2) << (ENTRY_W * i);
            mismatch_count = 0;
        endfunction

        // Rows past the last one are dropped, as the block drops them.
        function void load_row(int unsigned idx, cartan_row_t data);
            if (idx < NUM_ROWS)
                cartan[idx] = data;
        endfunction

        function int cartan_entry(int b, int k);
            logic signed [ENTRY_W-1:0] e;
            e = cartan[b][ENTRY_W*k +: ENTRY_W];
            return int'(e);
        endfunction

        // Reflect until strictly dominant, a wall is hit, the step cap runs out
        // or a coordinate leaves the 16-bit range.
        function dominant_t fold_to_chamber(weight_t w);
            int        n[NUM_COORDS];
            int        steps;
            int        hit;
            int        v;
            bit        minus;
            bit        wall;
            bit        over;
            bit        done;
            dominant_t r;
            for (int i = 0; i < NUM_COORDS; i++)
                n[i] = int'($signed(w[i]));
            steps = 0;
            minus = 1'b0;
            done  = 1'b0;
            r.status = STATUS_OVER;
            while (!done)
            begin
                hit  = -1;
                wall = 1'b0;
                for (int i = 0; i < RANK; i++)
                begin
                    if (hit < 0 && !wall)
                    begin
                        if (n[i] < 0)
                            hit = i;
                        else if (n[i] == 0)
                            wall = 1'b1;
                    end
                end
                if (wall)
                begin
                    r.status = STATUS_WALL;
                    done = 1'b1;
                end
                else if (hit < 0)
                begin
                    r.status = minus ? STATUS_MINUS : STATUS_PLUS;
                    done = 1'b1;
                end
                else if (steps >= MAX_STEPS)
                begin
                    r.status = STATUS_OVER;
                    done = 1'b1;
                end
                else
                begin
                    v    = n[hit];
                    over = 1'b0;
                    for (int k = 0; k < RANK; k++)
                    begin
                        n[k] -= v * cartan_entry(hit, k);
                        if (n[k] < -32768 || n[k] > 32767)
                            over = 1'b1;
                    end
                    steps++;
                    minus = !minus;
                    if (over)
                    begin
                        r.status = STATUS_OVER;
                        done = 1'b1;
                    end
                end
            end
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                if ((r.status == STATUS_PLUS || r.status == STATUS_MINUS) && i < RANK)
                    r.dom[i] = DOM_W'(n[i]);
                else
                    r.dom[i] = '0;
            end
            return r;
        endfunction

        function void note_weight(weight_t w);
            pending_dominants.push_back(fold_to_chamber(w));
        endfunction

        function int pending();
            return pending_dominants.size();
        endfunction

        function void report(string field, logic [DOM_W-1:0] expv, logic [DOM_W-1:0] gotv);
            $display("%0t ns: %s mismatch: expected %0d, got %0d",
                     $time, field, expv, gotv);
            mismatch_count++;
        endfunction

        function void check_dominant(dominant_t got);
            dominant_t exp_r;
            if (pending_dominants.size() == 0)
            begin
                $display("%0t ns: unexpected result: expected none, got status %0d",
                         $time, got.status);
                mismatch_count++;
                return;
            end
            exp_r = pending_dominants.pop_front();
            for (int i = 0; i < NUM_COORDS; i++)
                if (got.dom[i] !== exp_r.dom[i])
                    report($sformatf("dom_%0d", i), exp_r.dom[i], got.dom[i]);
            if (got.status !== exp_r.status)
                report("status", DOM_W'(exp_r.status), DOM_W'(got.status));
        endfunction
    endclass

endpackage

[dv/weyl_dominant_reflector_unit_tb.sv]
// Testbench top for the Weyl dominant reflector: stimulus, handshakes and the end of run.
`timescale 1ns / 1ps
module weyl_dominant_reflector_unit_tb;
    import wdr_pkg::*;
    import wdr_tb_pkg::*;

    // Register map: Cartan row b sits at index CARTAN_ROW_0 + b.
    localparam int CARTAN_ROW_0 = 0;
    localparam int CFG_IDX_MAX  = (1 << CFG_IDX_W) - 1;

    // Uniform rows: every entry the same 3-bit value.
    localparam cartan_row_t ROW_ALL_NEG1 = 24'hFFFFFF;
    localparam cartan_row_t ROW_ALL_NEG4 = 24'h924924;
    localparam cartan_row_t ROW_ALL_POS3 = 24'h6DB6DB;
    localparam cartan_row_t ROW_NULL     = 24'h000000;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 30;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    typedef enum int {
        KIND_DIAG,
        KIND_A,
        KIND_B,
        KIND_C,
        KIND_D,
        KIND_E,
        KIND_F4G2,
        KIND_ZERO,
        KIND_NEG4,
        KIND_EXTREME,
        KIND_RAND
    } cartan_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    weight_t              weight;
    logic                 out_valid;
    logic                 out_ready;
    logic [DOM_W-1:0]     dom_0, dom_1, dom_2, dom_3, dom_4, dom_5, dom_6, dom_7;
    logic [1:0]           status;

    dominant_result_book  sb;
    int                   tx_burst;

    weyl_dominant_reflector_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .coord_0   (weight[0]),
        .coord_1   (weight[1]),
        .coord_2   (weight[2]),
        .coord_3   (weight[3]),
        .coord_4   (weight[4]),
        .coord_5   (weight[5]),
        .coord_6   (weight[6]),
        .coord_7   (weight[7]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dom_0     (dom_0),
        .dom_1     (dom_1),
        .dom_2     (dom_2),
        .dom_3     (dom_3),
        .dom_4     (dom_4),
        .dom_5     (dom_5),
        .dom_6     (dom_6),
        .dom_7     (dom_7),
        .status    (status)
    );

    always #1 clk = ~clk;

    // Idle length for either side: mostly none or short, now and then long.
    // A calm stretch forces zero so both sides also run flat out for a while.
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic weight_t splat(int v);
        weight_t w;
        for (int i = 0; i < NUM_COORDS; i++)
            w[i] = IN_W'(v);
        return w;
    endfunction

    // Random weight. Most draws are small nonzero or all-negative vectors, which
    // under a real Cartan matrix walk a long way through the Weyl group; the rest
    // are wide values and raw bit patterns that reach walls and overflow.
    function automatic weight_t draw_weight();
        weight_t w;
        int      style;
        int      v;
        style = $urandom_range(0, 99);
        for (int i = 0; i < NUM_COORDS; i++)
        begin
            if (style < 45)
            begin
                v = $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
                if ($urandom_range(0, 19) == 0)
                    v = 0;
            end
            else if (style < 65)
                v = -int'($urandom_range(1, 4));
            else if (style < 85)
            begin
                v = $urandom_range(1, 300);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            else
                v = $urandom_range(0, 2047);
            w[i] = IN_W'(v);
        end
        return w;
    endfunction

    // Build the eight Cartan rows of one root system (or a degenerate set).
    function automatic void build_cartan(input cartan_kind_t kind,
                                         output cartan_row_t rows[NUM_ROWS]);
        int m[NUM_ROWS][NUM_ROWS];
        int ea[7];
        int eb[7];
        int pick;
        ea = '{0, 2, 3, 4, 5, 6, 1};
        eb = '{2, 3, 4, 5, 6, 7, 3};
        for (int i = 0; i < NUM_ROWS; i++)
            for (int j = 0; j < NUM_ROWS; j++)
                m[i][j] = (i == j) ? 2 : 0;
        case (kind)
            KIND_A, KIND_B, KIND_C:
            begin
                for (int i = 0; i < NUM_ROWS - 1; i++)
                begin
                    m[i][i+1] = -1;
                    m[i+1][i] = -1;
                end
                // double bond at the tail, long root on one side or the other
                if (kind == KIND_B)
                    m[6][7] = -2;
                if (kind == KIND_C)
                    m[7][6] = -2;
            end
            KIND_D:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    m[i][i+1] = -1;
                    m[i+1][i] = -1;
                end
                // fork: node 5 also links to node 7
                m[5][7] = -1;
                m[7][5] = -1;
            end
            KIND_E:
            begin
                for (int e = 0; e < 7; e++)
                begin
                    m[ea[e]][eb[e]] = -1;
                    m[eb[e]][ea[e]] = -1;
                end
            end
            KIND_F4G2:
            begin
                // F4 on nodes 0..3, G2 on nodes 4..5 (triple bond), 6 and 7 stay apart
                m[0][1] = -1;
                m[1][0] = -1;
                m[1][2] = -2;
                m[2][1] = -1;
                m[2][3] = -1;
                m[3][2] = -1;
                m[4][5] = -1;
                m[5][4] = -3;
            end
            KIND_ZERO:
            begin
                for (int i = 0; i < NUM_ROWS; i++)
                    m[i][i] = 0;
            end
            default:
            begin
            end
        endcase
        for (int b = 0; b < NUM_ROWS; b++)
            for (int k = 0; k < NUM_ROWS; k++)
                rows[b][ENTRY_W*k +: ENTRY_W] = ENTRY_W'(m[b][k]);
        for (int b = 0; b < NUM_ROWS; b++)
        begin
            if (kind == KIND_NEG4)
                rows[b] = ROW_ALL_NEG4;
            else if (kind == KIND_RAND)
                rows[b] = cartan_row_t'($urandom_range(0, 32'hFFFFFF));
            else if (kind == KIND_EXTREME)
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: rows[b] = ROW_ALL_NEG1;
                    1: rows[b] = ROW_ALL_NEG4;
                    2: rows[b] = ROW_ALL_POS3;
                    3: rows[b] = ROW_NULL;
                    default: rows[b] = cartan_row_t'(2) << (ENTRY_W * b);
                endcase
            end
        end
    endfunction

    // Load all rows back to back, then one write to an unmapped index that
    // must leave every row untouched.
    task automatic program_cartan(input cartan_kind_t kind);
        cartan_row_t rows[NUM_ROWS];
        build_cartan(kind, rows);
        for (int b = 0; b < NUM_ROWS; b++)
        begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = CFG_IDX_W'(CARTAN_ROW_0 + b);
            cfg_data  = rows[b];
            sb.load_row(CARTAN_ROW_0 + b, rows[b]);
        end
        @(negedge clk);
        cfg_index = CFG_IDX_W'($urandom_range(NUM_ROWS, CFG_IDX_MAX));
        cfg_data  = ROW_W'($urandom_range(0, 32'hFFFFFF));
        sb.load_row(cfg_index, cfg_data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold off the next request for a random gap; scramble the payload while
    // valid is low so the block has to ignore it.
    task automatic hold_off();
        int gap;
        gap = pick_gap(tx_burst > 0);
        if (tx_burst > 0)
            tx_burst--;
        else if ($urandom_range(0, 19) == 0)
            tx_burst = $urandom_range(10, 30);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            weight   = draw_weight();
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_weight(input weight_t w);
        @(negedge clk);
        in_valid = 1'b1;
        weight   = w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_weight(w);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Send the directed list, then a number of random requests. Now and then
    // stop and let the block empty completely before going on.
    task automatic feed(input weight_t plan[$], input int extra);
        foreach (plan[i])
        begin
            hold_off();
            send_weight(plan[i]);
        end
        for (int i = 0; i < extra; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                drain();
            hold_off();
            send_weight(draw_weight());
        end
    endtask

    // Result side: accept whenever ready meets valid at a rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_dominant(dominant_t'({dom_7, dom_6, dom_5, dom_4,
                                           dom_3, dom_2, dom_1, dom_0, status}));
    end

    // Result side backpressure, with calm stretches where ready stays high.
    initial
    begin : result_sink
        int stall;
        int calm;
        out_ready = 1'b0;
        stall = 0;
        calm  = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else
            begin
                out_ready = 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 49) == 0)
                    calm = $urandom_range(20, 80);
                stall = pick_gap(calm > 0);
            end
        end
    end

    initial
    begin : stimulus
        weight_t plan[$];
        weight_t w;
        sb        = new();
        tx_burst  = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        weight    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset rows (diagonal 2): each reflection just negates one coordinate.
        plan.push_back(splat(1));
        plan.push_back(splat(1023));
        plan.push_back(splat(-1024));
        plan.push_back(splat(0));
        w = splat(5);
        w[0] = IN_W'(-1);
        plan.push_back(w);                 // one flip: sign minus
        w = splat(7);
        w[0] = '0;
        plan.push_back(w);                 // wall on the first coordinate
        w = splat(2);
        w[7] = '0;
        plan.push_back(w);                 // wall on the last coordinate
        w = splat(3);
        w[3] = IN_W'(-9);
        w[5] = '0;
        plan.push_back(w);                 // reflect first, then hit the wall
        for (int i = 0; i < NUM_COORDS; i++)
            w[i] = (i % 2 == 0) ? IN_W'(-1024) : IN_W'(1023);
        plan.push_back(w);
        plan.push_back(splat(11'h555));
        plan.push_back(splat(11'h2AA));
        feed(plan, 80);

        // E8: minus rho needs the longest Weyl element, 120 reflections.
        drain();
        program_cartan(KIND_E);
        plan.delete();
        plan.push_back(splat(-1));
        plan.push_back(splat(1));
        w = splat(1);
        w[1] = IN_W'(-1);
        plan.push_back(w);
        plan.push_back(splat(-3));
        plan.push_back(splat(-1024));
        feed(plan, 150);

        // Classical and exceptional types with double and triple bonds.
        plan.delete();
        drain();
        program_cartan(KIND_A);
        feed(plan, 80);
        drain();
        program_cartan(KIND_B);
        feed(plan, 60);
        drain();
        program_cartan(KIND_C);
        feed(plan, 60);
        drain();
        program_cartan(KIND_D);
        feed(plan, 60);
        drain();
        program_cartan(KIND_F4G2);
        feed(plan, 60);

        // All-zero rows: a reflection changes nothing, so a negative coordinate
        // with no zero coordinate before it runs into the step cap.
        drain();
        program_cartan(KIND_ZERO);
        w = splat(4);
        w[2] = IN_W'(-1);
        plan.push_back(w);
        plan.push_back(splat(9));
        feed(plan, 20);

        // Every entry -4: coordinates grow fast and overflow the 16-bit range.
        drain();
        program_cartan(KIND_NEG4);
        plan.delete();
        plan.push_back(splat(-1024));
        plan.push_back(splat(-1));
        feed(plan, 20);

        // Uniform extreme rows mixed with diagonal ones, then fully random rows.
        plan.delete();
        drain();
        program_cartan(KIND_EXTREME);
        feed(plan, 50);
        drain();
        program_cartan(KIND_RAND);
        feed(plan, 80);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/wdr_pkg.sv
rtl/wdr_lane.sv
rtl/wdr_scan.sv
rtl/weyl_dominant_reflector_unit.sv
dv/wdr_tb_pkg.sv
dv/weyl_dominant_reflector_unit_tb.sv
